// ----- design/segment_box_clip_defines.svh -----
// Assertion macros shared by the segment clipper RTL.
`ifndef SEGMENT_BOX_CLIP_DEFINES_SVH
`define SEGMENT_BOX_CLIP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment_box_clip check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segment_box_clip check failed");

`endif

// ----- design/sbc_pkg.sv -----
// Shared types, constants and helper functions of the segment clipper.
`timescale 1ns / 1ps
package sbc_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // Differences of two coordinates need one extra bit.
   localparam int EXT_W   = COORD_WIDTH + 1;
   localparam int QUO_W   = COORD_WIDTH + 1;
   localparam int DVD_W   = EXT_W + FRAC_BITS;
   localparam int WIDE_W  = 2 * COORD_WIDTH + 1;
   localparam int DIV_LAT = QUO_W + 2;
   localparam int CSR_IDX_W = 2;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic signed [WIDE_W-1:0] WIDE_MAX =
      {{(WIDE_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] WIDE_MIN =
      {{(WIDE_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT   = 2'd0,
      CSR_RIGHT  = 2'd1,
      CSR_BOTTOM = 2'd2,
      CSR_TOP    = 2'd3
   } csr_idx_type;

   // Everything that travels alongside the dividers.
   typedef struct packed {
      logic                          valid;
      logic                          vert;
      logic                          flag;
      logic signed [COORD_WIDTH-1:0] ax;
      logic signed [COORD_WIDTH-1:0] ay;
      logic signed [COORD_WIDTH-1:0] bx;
      logic signed [COORD_WIDTH-1:0] by;
      logic signed [COORD_WIDTH-1:0] vl;
      logic signed [COORD_WIDTH-1:0] vr;
      logic                          vl_sat;
      logic                          vr_sat;
   } side_type;

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [WIDE_W-1:0] v);
      priority if (v > WIDE_MAX) begin
         return COORD_MAX;
      end else if (v < WIDE_MIN) begin
         return COORD_MIN;
      end else begin
         return v[COORD_WIDTH-1:0];
      end
   endfunction

   function automatic logic sat_hit(input logic signed [WIDE_W-1:0] v);
      return (v > WIDE_MAX) || (v < WIDE_MIN);
   endfunction

endpackage

// ----- design/sbc_div.sv -----
// Pipelined fixed-point divider, one quotient bit per stage, saturating.
`timescale 1ns / 1ps
module sbc_div (
   input  logic                                   clock,
   input  logic signed [sbc_pkg::EXT_W-1:0]       in_num,
   input  logic signed [sbc_pkg::EXT_W-1:0]       in_den,
   output logic signed [sbc_pkg::COORD_WIDTH-1:0] out_quo,
   output logic                                   out_sat
);

   typedef struct packed {
      logic neg;
      logic ovf;
      logic nz;
   } div_ctl_type;

   localparam logic [sbc_pkg::QUO_W-1:0] POS_LIMIT =
      {2'b00, {(sbc_pkg::COORD_WIDTH-1){1'b1}}};
   localparam logic [sbc_pkg::QUO_W-1:0] NEG_LIMIT =
      {2'b01, {(sbc_pkg::COORD_WIDTH-1){1'b0}}};

   logic [sbc_pkg::EXT_W-1:0] num_mag;
   logic [sbc_pkg::EXT_W-1:0] den_mag;
   logic [sbc_pkg::DVD_W-1:0] dvd;
   logic [sbc_pkg::EXT_W-1:0] dvd_top;

   logic [sbc_pkg::EXT_W-1:0] rem_ff [0:sbc_pkg::QUO_W];
   logic [sbc_pkg::QUO_W-1:0] lo_ff  [0:sbc_pkg::QUO_W];
   logic [sbc_pkg::QUO_W-1:0] quo_ff [0:sbc_pkg::QUO_W];
   logic [sbc_pkg::EXT_W-1:0] dsr_ff [0:sbc_pkg::QUO_W];
   div_ctl_type               ctl_ff [0:sbc_pkg::QUO_W];

   always_comb begin
      num_mag = in_num[sbc_pkg::EXT_W-1] ? -in_num : in_num;
      den_mag = in_den[sbc_pkg::EXT_W-1] ? -in_den : in_den;
      dvd     = {num_mag, {sbc_pkg::FRAC_BITS{1'b0}}};
      dvd_top = sbc_pkg::EXT_W'(dvd[sbc_pkg::DVD_W-1:sbc_pkg::QUO_W]);
   end

   // A quotient that does not fit the step count, or a zero divisor, shows up here.
   always_ff @(posedge clock) begin
      rem_ff[0] <= dvd_top;
      lo_ff[0]  <= dvd[sbc_pkg::QUO_W-1:0];
      quo_ff[0] <= '0;
      dsr_ff[0] <= den_mag;
      ctl_ff[0] <= '{neg: in_num[sbc_pkg::EXT_W-1] ^ in_den[sbc_pkg::EXT_W-1],
                     ovf: dvd_top >= den_mag,
                     nz:  in_num != '0};
   end

   for (genvar k = 0; k < sbc_pkg::QUO_W; k++) begin : g_step
      logic [sbc_pkg::EXT_W:0] trial;
      logic [sbc_pkg::EXT_W:0] diff;
      logic                    fits;

      always_comb begin
         trial = {rem_ff[k], lo_ff[k][sbc_pkg::QUO_W-1]};
         diff  = trial - {1'b0, dsr_ff[k]};
         fits  = trial >= {1'b0, dsr_ff[k]};
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= fits ? diff[sbc_pkg::EXT_W-1:0] : trial[sbc_pkg::EXT_W-1:0];
         lo_ff[k+1]  <= {lo_ff[k][sbc_pkg::QUO_W-2:0], 1'b0};
         quo_ff[k+1] <= {quo_ff[k][sbc_pkg::QUO_W-2:0], fits};
         dsr_ff[k+1] <= dsr_ff[k];
         ctl_ff[k+1] <= ctl_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      priority if (ctl_ff[sbc_pkg::QUO_W].ovf) begin
         out_sat <= 1'b1;
         out_quo <= !ctl_ff[sbc_pkg::QUO_W].nz ? '0 :
                    (ctl_ff[sbc_pkg::QUO_W].neg ? sbc_pkg::COORD_MIN : sbc_pkg::COORD_MAX);
      end else if (!ctl_ff[sbc_pkg::QUO_W].neg) begin
         out_sat <= quo_ff[sbc_pkg::QUO_W] > POS_LIMIT;
         out_quo <= (quo_ff[sbc_pkg::QUO_W] > POS_LIMIT) ? sbc_pkg::COORD_MAX :
                    quo_ff[sbc_pkg::QUO_W][sbc_pkg::COORD_WIDTH-1:0];
      end else begin
         out_sat <= quo_ff[sbc_pkg::QUO_W] > NEG_LIMIT;
         out_quo <= (quo_ff[sbc_pkg::QUO_W] > NEG_LIMIT) ? sbc_pkg::COORD_MIN :
                    sbc_pkg::COORD_WIDTH'(sbc_pkg::QUO_W'(0) - quo_ff[sbc_pkg::QUO_W]);
      end
   end

endmodule

// ----- design/sbc_delay.sv -----
// Delay line that carries the item alongside a divider.
`timescale 1ns / 1ps
module sbc_delay (
   input  logic              clock,
   input  logic              reset,
   input  sbc_pkg::side_type in_side,
   output sbc_pkg::side_type out_side
);

   sbc_pkg::side_type pipe_ff [0:sbc_pkg::DIV_LAT-1];
   sbc_pkg::side_type pipe_in [0:sbc_pkg::DIV_LAT-1];

   always_comb begin
      pipe_in[0]       = in_side;
      pipe_in[0].valid = in_side.valid && !reset;
      for (int k = 1; k < sbc_pkg::DIV_LAT; k++) begin
         pipe_in[k]       = pipe_ff[k-1];
         pipe_in[k].valid = pipe_ff[k-1].valid && !reset;
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff <= pipe_in;
   end

   assign out_side = pipe_ff[sbc_pkg::DIV_LAT-1];

endmodule

// ----- design/segment_box_clip.sv -----
// Top level of the segment clipper: registers, slope and edge pipeline, clip selection.
// Usage:
//   A segment enters on req_seg_* when start is high and busy is low; one item
//   can enter in every cycle. The clip rectangle is written through the csr_
//   channel (index 0 left, 1 right, 2 bottom, 3 top); the user must write it
//   only while no item is in flight; the block itself does not enforce this.
//   Each item gives one result on rsp_* with rsp_valid high for a single cycle, in
//   input order. The pipeline is two dividers of COORD_WIDTH + 3 stages each (slope,
//   then the top and bottom edge crossings) plus seven stages: input capture,
//   intercept multiply and clamp, edge multiplies and clamp, and two clip selection
//   stages. Throughput is one item per cycle. rsp_saturated flags a slope,
//   intercept or used edge value that was clamped; it is low for a vertical segment.
//   Reset is synchronous; it reaches busy (high) and csr_ready (low) through a
//   register; all items in flight are dropped and the rectangle returns to all zeros.
//   The receiver cannot stall: results are never held, so nothing backs up.
`timescale 1ns / 1ps
`include "segment_box_clip_defines.svh"
module segment_box_clip (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [sbc_pkg::COORD_WIDTH-1:0] req_seg_ax,
   input  logic signed [sbc_pkg::COORD_WIDTH-1:0] req_seg_ay,
   input  logic signed [sbc_pkg::COORD_WIDTH-1:0] req_seg_bx,
   input  logic signed [sbc_pkg::COORD_WIDTH-1:0] req_seg_by,
   output logic                                   rsp_valid,
   output logic signed [sbc_pkg::COORD_WIDTH-1:0] rsp_out_ax,
   output logic signed [sbc_pkg::COORD_WIDTH-1:0] rsp_out_ay,
   output logic signed [sbc_pkg::COORD_WIDTH-1:0] rsp_out_bx,
   output logic signed [sbc_pkg::COORD_WIDTH-1:0] rsp_out_by,
   output logic                                   rsp_saturated,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sbc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [sbc_pkg::COORD_WIDTH-1:0]        csr_data
);

   localparam int W  = sbc_pkg::COORD_WIDTH;
   localparam int EW = sbc_pkg::EXT_W;
   localparam int WW = sbc_pkg::WIDE_W;

   logic busy_ff;
   logic signed [W-1:0] box_left_ff, box_right_ff, box_bottom_ff, box_top_ff;

   sbc_pkg::side_type s0_ff, d1_side, t1_ff, t2_ff, t3_ff, t4_ff, d2_side, t5_ff;
   sbc_pkg::side_type s0_in, t1_in, t2_in, t3_in, t4_in, t5_in;
   logic signed [EW-1:0]  dx_ff, dy_ff;
   logic signed [W-1:0]   m_quo, vt_quo, vb_quo;
   logic                  m_sat, vt_sat, vb_sat;
   logic signed [W-1:0]   m1_ff, m2_ff, p2_ff, p3_ff;
   logic signed [2*W-1:0] prod_b_ff, prod_l_ff, prod_r_ff;
   logic                  msat1_ff;
   logic signed [WW-1:0]  p_wide, vl_wide, vr_wide;
   logic signed [EW-1:0]  num_top3_ff, num_bot3_ff, den3_ff;
   logic signed [EW-1:0]  num_top4_ff, num_bot4_ff, den4_ff;

   logic                  rsp_valid_ff, rsp_sat_ff;
   logic signed [W-1:0]   rsp_ax_ff, rsp_ay_ff, rsp_bx_ff, rsp_by_ff;
   logic signed [W-1:0]   fin_ax, fin_ay, fin_bx, fin_by;
   logic                  fin_flag;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff   <= '0;
         box_right_ff  <= '0;
         box_bottom_ff <= '0;
         box_top_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (sbc_pkg::csr_idx_type'(csr_index))
            sbc_pkg::CSR_LEFT:   box_left_ff   <= csr_data;
            sbc_pkg::CSR_RIGHT:  box_right_ff  <= csr_data;
            sbc_pkg::CSR_BOTTOM: box_bottom_ff <= csr_data;
            sbc_pkg::CSR_TOP:    box_top_ff    <= csr_data;
         endcase
      end
   end

   // Capture the item and form the exact differences.
   always_comb begin
      s0_in       = '0;
      s0_in.valid = start && !busy_ff && !reset;
      s0_in.vert  = req_seg_ax == req_seg_bx;
      s0_in.ax    = req_seg_ax;
      s0_in.ay    = req_seg_ay;
      s0_in.bx    = req_seg_bx;
      s0_in.by    = req_seg_by;
   end

   always_ff @(posedge clock) begin
      s0_ff <= s0_in;
      dx_ff <= EW'(req_seg_bx) - EW'(req_seg_ax);
      dy_ff <= EW'(req_seg_by) - EW'(req_seg_ay);
   end

   sbc_div u_div_slope (
      .clock   (clock),
      .in_num  (dy_ff),
      .in_den  (dx_ff),
      .out_quo (m_quo),
      .out_sat (m_sat)
   );

   sbc_delay u_delay_slope (
      .clock    (clock),
      .reset    (reset),
      .in_side  (s0_ff),
      .out_side (d1_side)
   );

   // Intercept: multiply, then shift, subtract and clamp.
   always_comb begin
      t1_in       = d1_side;
      t1_in.valid = d1_side.valid && !reset;
   end

   always_ff @(posedge clock) begin
      t1_ff     <= t1_in;
      m1_ff     <= m_quo;
      msat1_ff  <= m_sat;
      prod_b_ff <= m_quo * d1_side.bx;
   end

   assign p_wide = WW'(t1_ff.by) - WW'(prod_b_ff >>> sbc_pkg::FRAC_BITS);

   always_comb begin
      t2_in       = t1_ff;
      t2_in.valid = t1_ff.valid && !reset;
      t2_in.flag  = msat1_ff | sbc_pkg::sat_hit(p_wide);
   end

   always_ff @(posedge clock) begin
      t2_ff <= t2_in;
      m2_ff <= m1_ff;
      p2_ff <= sbc_pkg::sat_coord(p_wide);
   end

   // Left and right edge products; top and bottom numerators for the dividers.
   always_comb begin
      t3_in       = t2_ff;
      t3_in.valid = t2_ff.valid && !reset;
   end

   always_ff @(posedge clock) begin
      t3_ff       <= t3_in;
      prod_l_ff   <= m2_ff * box_left_ff;
      prod_r_ff   <= m2_ff * box_right_ff;
      p3_ff       <= p2_ff;
      num_top3_ff <= EW'(box_top_ff) - EW'(p2_ff);
      num_bot3_ff <= EW'(box_bottom_ff) - EW'(p2_ff);
      den3_ff     <= EW'(m2_ff);
   end

   assign vl_wide = WW'(prod_l_ff >>> sbc_pkg::FRAC_BITS) + WW'(p3_ff);
   assign vr_wide = WW'(prod_r_ff >>> sbc_pkg::FRAC_BITS) + WW'(p3_ff);

   always_comb begin
      t4_in        = t3_ff;
      t4_in.valid  = t3_ff.valid && !reset;
      t4_in.vl     = sbc_pkg::sat_coord(vl_wide);
      t4_in.vr     = sbc_pkg::sat_coord(vr_wide);
      t4_in.vl_sat = sbc_pkg::sat_hit(vl_wide);
      t4_in.vr_sat = sbc_pkg::sat_hit(vr_wide);
   end

   always_ff @(posedge clock) begin
      t4_ff       <= t4_in;
      num_top4_ff <= num_top3_ff;
      num_bot4_ff <= num_bot3_ff;
      den4_ff     <= den3_ff;
   end

   sbc_div u_div_top (
      .clock   (clock),
      .in_num  (num_top4_ff),
      .in_den  (den4_ff),
      .out_quo (vt_quo),
      .out_sat (vt_sat)
   );

   sbc_div u_div_bottom (
      .clock   (clock),
      .in_num  (num_bot4_ff),
      .in_den  (den4_ff),
      .out_quo (vb_quo),
      .out_sat (vb_sat)
   );

   sbc_delay u_delay_edge (
      .clock    (clock),
      .reset    (reset),
      .in_side  (t4_ff),
      .out_side (d2_side)
   );

   // Top then bottom; each test sees what the earlier one left.
   always_comb begin
      t5_in       = d2_side;
      t5_in.valid = d2_side.valid && !reset;
      if (!d2_side.vert) begin
         if (t5_in.ay >= box_top_ff) begin
            t5_in.ax   = vt_quo;
            t5_in.ay   = box_top_ff;
            t5_in.flag = t5_in.flag | vt_sat;
         end else if (t5_in.by >= box_top_ff) begin
            t5_in.bx   = vt_quo;
            t5_in.by   = box_top_ff;
            t5_in.flag = t5_in.flag | vt_sat;
         end
         if (t5_in.ay <= box_bottom_ff) begin
            t5_in.ax   = vb_quo;
            t5_in.ay   = box_bottom_ff;
            t5_in.flag = t5_in.flag | vb_sat;
         end else if (t5_in.by <= box_bottom_ff) begin
            t5_in.bx   = vb_quo;
            t5_in.by   = box_bottom_ff;
            t5_in.flag = t5_in.flag | vb_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      t5_ff <= t5_in;
   end

   // Left then right.
   always_comb begin
      fin_ax   = t5_ff.ax;
      fin_ay   = t5_ff.ay;
      fin_bx   = t5_ff.bx;
      fin_by   = t5_ff.by;
      fin_flag = t5_ff.flag;
      if (!t5_ff.vert) begin
         if (fin_ax <= box_left_ff) begin
            fin_ax   = box_left_ff;
            fin_ay   = t5_ff.vl;
            fin_flag = fin_flag | t5_ff.vl_sat;
         end else if (fin_bx <= box_left_ff) begin
            fin_bx   = box_left_ff;
            fin_by   = t5_ff.vl;
            fin_flag = fin_flag | t5_ff.vl_sat;
         end
         if (fin_ax >= box_right_ff) begin
            fin_ax   = box_right_ff;
            fin_ay   = t5_ff.vr;
            fin_flag = fin_flag | t5_ff.vr_sat;
         end else if (fin_bx >= box_right_ff) begin
            fin_bx   = box_right_ff;
            fin_by   = t5_ff.vr;
            fin_flag = fin_flag | t5_ff.vr_sat;
         end
      end else begin
         fin_flag = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= t5_ff.valid;
      end
      rsp_ax_ff  <= fin_ax;
      rsp_ay_ff  <= fin_ay;
      rsp_bx_ff  <= fin_bx;
      rsp_by_ff  <= fin_by;
      rsp_sat_ff <= fin_flag;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_ax    = rsp_ax_ff;
   assign rsp_out_ay    = rsp_ay_ff;
   assign rsp_out_bx    = rsp_bx_ff;
   assign rsp_out_by    = rsp_by_ff;
   assign rsp_saturated = rsp_sat_ff;

   `SBC_ASSERT_SAME(a_edge_to_rsp, clock, reset, t4_ff.valid, ##(sbc_pkg::DIV_LAT + 2) rsp_valid_ff)
   `SBC_ASSERT_NEXT(a_vert_no_sat, clock, reset, t5_ff.valid && t5_ff.vert, !rsp_saturated)
   `SBC_ASSERT_NEXT(a_vert_pass, clock, reset, t5_ff.valid && t5_ff.vert, rsp_out_ax == $past(t5_ff.ax) && rsp_out_by == $past(t5_ff.by))
   `SBC_ASSERT_NEXT(a_busy_blocks, clock, reset, busy_ff, !s0_ff.valid)

endmodule
